>>> sv/fdmf_pkg.sv
// Package for the frequency-domain mask filter: payload structs, mode codes,
// register indexes, gain constants and the 2^(-k/16) table. No dependencies.
`timescale 1ns / 1ps
package fdmf_pkg;

    localparam int MAX_LOG2_SIDE_DEF = 9;
    localparam int COL_W             = 9;
    localparam int CUT_W             = 14;
    localparam int LG_W              = 4;
    localparam int MODE_W            = 3;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 14;
    localparam int GAIN_W            = 17;

    localparam logic [GAIN_W-1:0]    ONE_Q16    = 17'd65536;
    localparam logic [24:0]          LOG2E_Q24  = 25'd24204406;
    localparam logic [15:0]          LN2_Q16    = 16'd45426;
    localparam logic [CUT_W-1:0]     CUT_RESET  = 14'd480;
    localparam logic [LG_W-1:0]      LG_RESET   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2   = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS        = 3'd0,
        MODE_IDEAL_LOW   = 3'd1,
        MODE_BW_LOW      = 3'd2,
        MODE_GAUSS_LOW   = 3'd3,
        MODE_IDEAL_HIGH  = 3'd4,
        MODE_BW_HIGH     = 3'd5,
        MODE_GAUSS_HIGH  = 3'd6
    } t_mode;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  row;
        logic signed [31:0] re_in;
        logic signed [31:0] im_in;
    } t_in_s;

    typedef struct packed {
        logic signed [31:0] re_out;
        logic signed [31:0] im_out;
        logic [GAIN_W-1:0]  gain;
    } t_out_s;

    // what rides along the divider and gain stages
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [MODE_W-1:0]  mode;
        logic               ovf;
        logic [GAIN_W-1:0]  h_fix;
    } t_carry;

    function automatic logic [GAIN_W-1:0] pow2_neg_16th(input logic [3:0] k);
        logic [GAIN_W-1:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd62757;
            4'd2:  v = 17'd60097;
            4'd3:  v = 17'd57549;
            4'd4:  v = 17'd55109;
            4'd5:  v = 17'd52773;
            4'd6:  v = 17'd50535;
            4'd7:  v = 17'd48393;
            4'd8:  v = 17'd46341;
            4'd9:  v = 17'd44376;
            4'd10: v = 17'd42495;
            4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;
            4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

>>> sv/frequency_domain_mask_filter_top.sv
// Throughput one per cycle while the output is not stalled.
// Stages: offsets, squares and divider setup (4), restoring divider one quotient bit per
// stage (22), gaussian table and polynomial (4), part scaling and saturation (2).
// A stall on the output freezes the whole pipeline; no bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and loads register defaults:
// mode pass, cutoff 480, log2 side 8. Depends on fdmf_pkg.
`timescale 1ns / 1ps
module frequency_domain_mask_filter_top #(
    parameter int MAX_LOG2_SIDE = fdmf_pkg::MAX_LOG2_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  fdmf_pkg::t_in_s                   i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output fdmf_pkg::t_out_s                  o_data,
    input  logic                              i_cfg_we,
    input  logic [fdmf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW   = (MAX_LOG2_SIDE > fdmf_pkg::COL_W) ? MAX_LOG2_SIDE : fdmf_pkg::COL_W;
    localparam int SW   = 2 * CW + 1;
    localparam int BW   = SW + 8;
    localparam int AW   = 2 * fdmf_pkg::CUT_W;
    localparam int A2W  = 2 * AW;
    localparam int B2W  = 2 * BW;
    localparam int NW   = BW + 25;
    localparam int MW   = (A2W > B2W) ? A2W : B2W;
    localparam int DGW  = AW + 9;
    localparam int DW0  = (MW > DGW) ? MW + 1 : DGW;
    localparam int DW   = (DW0 > NW - 22) ? DW0 : NW - 22;
    localparam int RW   = DW + 1;
    localparam int QW   = 22;
    localparam int NST  = 4 + QW + 6;
    localparam int GW   = fdmf_pkg::GAIN_W;
    localparam int CMW  = (AW > BW) ? AW : BW;

    // ---------------- configuration ----------------
    logic [fdmf_pkg::MODE_W-1:0] r_mode;
    logic [fdmf_pkg::CUT_W-1:0]  r_cut;
    logic [fdmf_pkg::LG_W-1:0]   r_lg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fdmf_pkg::MODE_PASS;
            r_cut  <= fdmf_pkg::CUT_RESET;
            r_lg   <= fdmf_pkg::LG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fdmf_pkg::REG_MODE)
                r_mode <= i_cfg_data[fdmf_pkg::MODE_W-1:0];
            else if (i_cfg_idx == fdmf_pkg::REG_CUTOFF)
                r_cut <= i_cfg_data[fdmf_pkg::CUT_W-1:0];
            else if (i_cfg_idx == fdmf_pkg::REG_LOG2)
                r_lg <= i_cfg_data[fdmf_pkg::LG_W-1:0];
        end
    end

    // ---------------- flow control ----------------
    logic [NST-1:0] r_vld;
    logic           en;
    logic           acc;

    assign en      = !(r_vld[NST-1] && i_stall);
    assign o_stall = r_vld[NST-1] && i_stall;
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], acc};
        end
    end

    // ---------------- S1: offsets from center ----------------
    logic [fdmf_pkg::LG_W-1:0] lgc;
    logic [CW-1:0]             center;
    logic signed [CW:0]        r1_du, r1_dv;
    logic [fdmf_pkg::CUT_W-1:0] r1_cut;
    logic [fdmf_pkg::MODE_W-1:0] r1_mode;
    logic signed [31:0]        r1_re, r1_im;

    always_comb begin
        if (r_lg < fdmf_pkg::LG_W'(1))
            lgc = fdmf_pkg::LG_W'(1);
        else if (r_lg > fdmf_pkg::LG_W'(MAX_LOG2_SIDE))
            lgc = fdmf_pkg::LG_W'(MAX_LOG2_SIDE);
        else
            lgc = r_lg;
        center = CW'(1) << (lgc - fdmf_pkg::LG_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_du   <= $signed({1'b0, CW'(i_data.col)}) - $signed({1'b0, center});
            r1_dv   <= $signed({1'b0, CW'(i_data.row)}) - $signed({1'b0, center});
            r1_cut  <= (r_cut == '0) ? fdmf_pkg::CUT_W'(1) : r_cut;
            r1_mode <= r_mode;
            r1_re   <= i_data.re_in;
            r1_im   <= i_data.im_in;
        end
    end

    // ---------------- S2: squares ----------------
    logic signed [2*CW+1:0] sq_u, sq_v;
    logic [BW-1:0]          r2_b;
    logic [AW-1:0]          r2_a;
    logic [fdmf_pkg::MODE_W-1:0] r2_mode;
    logic signed [31:0]     r2_re, r2_im;

    assign sq_u = r1_du * r1_du;
    assign sq_v = r1_dv * r1_dv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_b    <= {SW'(sq_u[2*CW-1:0]) + SW'(sq_v[2*CW-1:0]), 8'b0};
            r2_a    <= AW'(r1_cut) * AW'(r1_cut);
            r2_mode <= r1_mode;
            r2_re   <= r1_re;
            r2_im   <= r1_im;
        end
    end

    // ---------------- S3: A^2, B^2, gaussian numerator ----------------
    logic [AW-1:0]  r3_a;
    logic [BW-1:0]  r3_b;
    logic [A2W-1:0] r3_a2;
    logic [B2W-1:0] r3_b2;
    logic [NW-1:0]  r3_n;
    logic [fdmf_pkg::MODE_W-1:0] r3_mode;
    logic signed [31:0] r3_re, r3_im;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_a2   <= A2W'(r2_a) * A2W'(r2_a);
            r3_b2   <= B2W'(r2_b) * B2W'(r2_b);
            r3_n    <= NW'(r2_b) * NW'(fdmf_pkg::LOG2E_Q24);
            r3_mode <= r2_mode;
            r3_re   <= r2_re;
            r3_im   <= r2_im;
        end
    end

    // ---------------- S4: divider setup ----------------
    // Gaussian: y = N / (A*512). Butterworth: round(2^16 * num / (A^2 + B^2)) taken
    // from an 18-bit quotient of num * 2^17.
    logic [RW-1:0] r_dr [0:QW-1];
    logic [DW-1:0] r_dd [0:QW-1];
    logic [QW-1:0] r_dl [0:QW-1];
    logic [QW-1:0] r_dq [0:QW];
    fdmf_pkg::t_carry r_dc [0:QW];

    logic [DW-1:0] s4_den, s4_hi;
    logic [QW-1:0] s4_lo;
    logic [MW-1:0] s4_num;
    logic [GW-1:0] s4_hfix;
    logic          s4_gauss;
    logic [A2W:0]  s4_bsum;

    always_comb begin
        s4_gauss = (r3_mode == fdmf_pkg::MODE_GAUSS_LOW) ||
                   (r3_mode == fdmf_pkg::MODE_GAUSS_HIGH);
        s4_num   = (r3_mode == fdmf_pkg::MODE_BW_LOW) ? MW'(r3_a2) : MW'(r3_b2);
        s4_bsum  = (A2W+1)'(r3_a2) + (A2W+1)'(r3_b2);
        if (s4_gauss) begin
            s4_den = DW'({r3_a, 9'b0});
            s4_hi  = DW'(r3_n >> QW);
            s4_lo  = r3_n[QW-1:0];
        end else begin
            s4_den = DW'(s4_bsum);
            s4_hi  = DW'(s4_num >> 5);
            s4_lo  = {s4_num[4:0], 17'b0};
        end
        unique case (r3_mode)
            fdmf_pkg::MODE_IDEAL_LOW:
                s4_hfix = (CMW'(r3_b) <= CMW'(r3_a)) ? fdmf_pkg::ONE_Q16 : '0;
            fdmf_pkg::MODE_IDEAL_HIGH:
                s4_hfix = (CMW'(r3_b) < CMW'(r3_a)) ? '0 : fdmf_pkg::ONE_Q16;
            default:
                s4_hfix = fdmf_pkg::ONE_Q16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dr[0]       <= RW'(s4_hi);
            r_dd[0]       <= s4_den;
            r_dl[0]       <= s4_lo;
            r_dq[0]       <= '0;
            r_dc[0].re    <= r3_re;
            r_dc[0].im    <= r3_im;
            r_dc[0].mode  <= r3_mode;
            r_dc[0].ovf   <= (s4_hi >= s4_den);
            r_dc[0].h_fix <= s4_hfix;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        logic [RW-1:0] trial;
        logic          ge;
        assign trial = {r_dr[gi][RW-2:0], r_dl[gi][QW-1]};
        assign ge    = trial >= {1'b0, r_dd[gi]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dq[gi+1] <= {r_dq[gi][QW-2:0], ge};
                r_dc[gi+1] <= r_dc[gi];
            end
        end
        // the last stage only yields its quotient bit
        if (gi < QW - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dr[gi+1] <= ge ? (trial - {1'b0, r_dd[gi]}) : trial;
                    r_dd[gi+1] <= r_dd[gi];
                    r_dl[gi+1] <= {r_dl[gi][QW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- G1: ratio rounding, gaussian t ----------------
    logic [QW-1:0]  q;
    logic [18:0]    g1_rsum;
    logic [27:0]    g1_tp;
    fdmf_pkg::t_carry r_g1_c;
    logic [GW-1:0]  r_g1_ratio;
    logic [11:0]    r_g1_t;
    logic [3:0]     r_g1_k;
    logic [4:0]     r_g1_n;
    logic           r_g1_z;

    assign q       = r_dq[QW];
    assign g1_rsum = 19'(q[17:0]) + 19'd1;
    assign g1_tp   = 28'(q[11:0]) * 28'(fdmf_pkg::LN2_Q16);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_c     <= r_dc[QW];
            r_g1_ratio <= (g1_rsum[18:1] > 18'(fdmf_pkg::ONE_Q16)) ? fdmf_pkg::ONE_Q16
                                                                   : g1_rsum[17:1];
            r_g1_t     <= g1_tp[27:16];
            r_g1_k     <= q[15:12];
            r_g1_n     <= q[20:16];
            r_g1_z     <= r_dc[QW].ovf || q[21] || (q[20:16] > 5'd16);
        end
    end

    // ---------------- G2: polynomial p = 1 - t + t^2/2 ----------------
    // The cubic term stays below one unit since t is at most 2838, and drops out.
    logic [23:0]    g2_tt;
    fdmf_pkg::t_carry r_g2_c;
    logic [GW-1:0]  r_g2_ratio, r_g2_p;
    logic [3:0]     r_g2_k;
    logic [4:0]     r_g2_n;
    logic           r_g2_z;

    assign g2_tt = 24'(r_g1_t) * 24'(r_g1_t);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g2_c     <= r_g1_c;
            r_g2_ratio <= r_g1_ratio;
            r_g2_p     <= fdmf_pkg::ONE_Q16 - GW'(r_g1_t) + GW'(g2_tt[23:17]);
            r_g2_k     <= r_g1_k;
            r_g2_n     <= r_g1_n;
            r_g2_z     <= r_g1_z;
        end
    end

    // ---------------- G3: table times polynomial ----------------
    fdmf_pkg::t_carry r_g3_c;
    logic [GW-1:0]  r_g3_ratio;
    logic [33:0]    r_g3_prod;
    logic [4:0]     r_g3_n;
    logic           r_g3_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g3_c     <= r_g2_c;
            r_g3_ratio <= r_g2_ratio;
            r_g3_prod  <= 34'(fdmf_pkg::pow2_neg_16th(r_g2_k)) * 34'(r_g2_p);
            r_g3_n     <= r_g2_n;
            r_g3_z     <= r_g2_z;
        end
    end

    // ---------------- G4: shift, pick gain ----------------
    logic [48:0]    g4_sum, g4_sh;
    logic [GW-1:0]  g4_g, g4_h;
    fdmf_pkg::t_carry r_g4_c;
    logic [GW-1:0]  r_g4_h;

    always_comb begin
        g4_sum = 49'(r_g3_prod) + (49'd1 << (6'(r_g3_n) + 6'd31));
        g4_sh  = g4_sum >> (6'(r_g3_n) + 6'd32);
        if (r_g3_z)
            g4_g = '0;
        else if (g4_sh > 49'(fdmf_pkg::ONE_Q16))
            g4_g = fdmf_pkg::ONE_Q16;
        else
            g4_g = g4_sh[GW-1:0];
        unique case (r_g3_c.mode)
            fdmf_pkg::MODE_BW_LOW,
            fdmf_pkg::MODE_BW_HIGH:    g4_h = r_g3_ratio;
            fdmf_pkg::MODE_GAUSS_LOW:  g4_h = g4_g;
            fdmf_pkg::MODE_GAUSS_HIGH: g4_h = fdmf_pkg::ONE_Q16 - g4_g;
            default:                   g4_h = r_g3_c.h_fix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g4_c <= r_g3_c;
            r_g4_h <= g4_h;
        end
    end

    // ---------------- M1: magnitude times gain ----------------
    logic [31:0] m1_mre, m1_mim;
    logic [48:0] m1_pre, m1_pim;
    logic [32:0] r_m1_qre, r_m1_qim;
    logic        r_m1_nre, r_m1_nim;
    logic [GW-1:0] r_m1_h;

    always_comb begin
        m1_mre = r_g4_c.re[31] ? 32'(33'h1_0000_0000 - {1'b0, r_g4_c.re}) : r_g4_c.re;
        m1_mim = r_g4_c.im[31] ? 32'(33'h1_0000_0000 - {1'b0, r_g4_c.im}) : r_g4_c.im;
        m1_pre = 49'(m1_mre) * 49'(r_g4_h) + 49'd32768;
        m1_pim = 49'(m1_mim) * 49'(r_g4_h) + 49'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_qre <= m1_pre[48:16];
            r_m1_qim <= m1_pim[48:16];
            r_m1_nre <= r_g4_c.re[31];
            r_m1_nim <= r_g4_c.im[31];
            r_m1_h   <= r_g4_h;
        end
    end

    // ---------------- M2: saturate, restore sign ----------------
    function automatic logic [31:0] sat_part(input logic [32:0] qv, input logic neg);
        logic [32:0] c;
        if (neg) begin
            c = (qv > 33'h0_8000_0000) ? 33'h0_8000_0000 : qv;
            return 32'(33'h1_0000_0000 - c);
        end
        c = (qv > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : qv;
        return c[31:0];
    endfunction

    fdmf_pkg::t_out_s r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.re_out <= sat_part(r_m1_qre, r_m1_nre);
            r_out.im_out <= sat_part(r_m1_qim, r_m1_nim);
            r_out.gain   <= r_m1_h;
        end
    end

    assign o_data = r_out;

    // ---------------- assertions ----------------
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.gain <= fdmf_pkg::ONE_Q16))
        else $error("gain above one");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.gain == '0) |-> (o_data.re_out == 0 && o_data.im_out == 0))
        else $error("nonzero output with zero gain");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && i_stall) |=> $stable(r_vld) && $stable(r_g4_h))
        else $error("pipeline moved under stall");

endmodule

>>> tb/tb_top.sv
// Self-checking bench for frequency_domain_mask_filter_top: a gain predictor,
// random coefficient stream and a queue scoreboard. Depends on fdmf_pkg.
`timescale 1ns / 1ps
module tb_top;

    localparam int LIMIT = 400000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0, i_cfg_we = 0;
    fdmf_pkg::t_in_s i_data = '0;
    logic [fdmf_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fdmf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid;
    fdmf_pkg::t_out_s o_data;

    logic [2:0] cur_mode = 3'd0;
    logic [13:0] cur_cut = fdmf_pkg::CUT_RESET;
    logic [3:0] cur_lg = fdmf_pkg::LG_RESET;
    int errors = 0;
    int cycles = 0;
    int quiet = 0;

    frequency_domain_mask_filter_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic logic [16:0] ratio16(logic [63:0] num, logic [63:0] den);
        logic [31:0] q;
        logic [63:0] r;
        q = 0;
        r = num;
        if (r >= den) begin
            q = 1;
            r -= den;
        end
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den;
                q[0] = 1;
            end
        end
        if ((r << 1) >= den) q++;
        return (q > 65536) ? fdmf_pkg::ONE_Q16 : q[16:0];
    endfunction

    function automatic logic [16:0] gauss16(logic [63:0] a, logic [63:0] b);
        logic [63:0] y, n, r, t, p, prod;
        logic [3:0] k;
        logic [31:0] tab [16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
            48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
        y = (b * 64'd24204406) / (a * 64'd512);
        n = y >> 16;
        k = y[15:12];
        r = y[11:0];
        if (n > 16) return 17'd0;
        t = (r * 64'd45426) >> 16;
        p = 64'd65536 - t + ((t * t) >> 17) - ((t * t * t) / 64'd25769803776);
        prod = tab[k] * p;
        prod = (prod + (64'd1 << (31 + n))) >> (32 + n);
        return (prod > 65536) ? fdmf_pkg::ONE_Q16 : prod[16:0];
    endfunction

    function automatic logic [31:0] scaled(logic [31:0] v, logic [16:0] h);
        logic [63:0] mag, q;
        mag = v[31] ? (64'h1_0000_0000 - v) : {32'd0, v};
        q = (mag * h + 64'd32768) >> 16;
        if (v[31]) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(64'h1_0000_0000 - q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic fdmf_pkg::t_out_s filtered(fdmf_pkg::t_in_s x);
        fdmf_pkg::t_out_s o;
        int lg;
        longint c, du, dv;
        logic [63:0] a, b, a2, b2;
        logic [16:0] h;
        lg = (cur_lg < 1) ? 1 : (cur_lg > fdmf_pkg::MAX_LOG2_SIDE_DEF ?
             fdmf_pkg::MAX_LOG2_SIDE_DEF : cur_lg);
        c = longint'(1) << (lg - 1);
        du = longint'(x.col) - c;
        dv = longint'(x.row) - c;
        b = (du * du + dv * dv) * 256;
        a = (cur_cut == 0) ? 64'd1 : cur_cut * cur_cut;
        a2 = a * a;
        b2 = b * b;
        case (cur_mode)
            fdmf_pkg::MODE_IDEAL_LOW:  h = (b <= a) ? fdmf_pkg::ONE_Q16 : 17'd0;
            fdmf_pkg::MODE_BW_LOW:     h = ratio16(a2, a2 + b2);
            fdmf_pkg::MODE_GAUSS_LOW:  h = gauss16(a, b);
            fdmf_pkg::MODE_IDEAL_HIGH: h = (b < a) ? 17'd0 : fdmf_pkg::ONE_Q16;
            fdmf_pkg::MODE_BW_HIGH:    h = ratio16(b2, a2 + b2);
            fdmf_pkg::MODE_GAUSS_HIGH: h = fdmf_pkg::ONE_Q16 - gauss16(a, b);
            default:                   h = fdmf_pkg::ONE_Q16;
        endcase
        o.re_out = scaled(x.re_in, h);
        o.im_out = scaled(x.im_in, h);
        o.gain = h;
        return o;
    endfunction

    class coeff_board;
        fdmf_pkg::t_out_s pending[$];
        function void note_request(fdmf_pkg::t_out_s e);
            pending.push_back(e);
        endfunction
        function void check_result(fdmf_pkg::t_out_s got);
            fdmf_pkg::t_out_s e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.re_out !== e.re_out)
                $display("%0t: re_out exp %0d got %0d", $time, e.re_out, got.re_out);
            if (got.im_out !== e.im_out)
                $display("%0t: im_out exp %0d got %0d", $time, e.im_out, got.im_out);
            if (got.gain !== e.gain)
                $display("%0t: gain exp %0d got %0d", $time, e.gain, got.gain);
            if (got !== e) errors++;
        endfunction
    endclass

    coeff_board board = new();

    // receiver side: random stall, calm stretch in the middle
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_data);
        i_stall <= (quiet == 0) && ($urandom_range(99) < 25);
    end

    task automatic write_reg(logic [fdmf_pkg::CFG_IDX_W-1:0] idx,
                             logic [fdmf_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == fdmf_pkg::REG_MODE) cur_mode = val[2:0];
        else if (idx == fdmf_pkg::REG_CUTOFF) cur_cut = val;
        else if (idx == fdmf_pkg::REG_LOG2) cur_lg = val[3:0];
    endtask

    task automatic send(fdmf_pkg::t_in_s x);
        int gap;
        i_valid <= 1;
        i_data <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(filtered(x));
        if (quiet == 0 && $urandom_range(99) < 25) begin
            gap = $urandom_range(3, 1);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int n;
        i_valid <= 0;
        n = 0;
        while (board.pending.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic fdmf_pkg::t_in_s rnd_coeff(int lg);
        fdmf_pkg::t_in_s x;
        int side;
        side = 1 << ((lg < 1) ? 1 : (lg > 9 ? 9 : lg));
        x.col = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(side - 1));
        x.row = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(side - 1));
        case ($urandom_range(5))
            0: x.re_in = 32'h8000_0000;
            1: x.re_in = 32'h7FFF_FFFF;
            2: x.re_in = $urandom_range(200) - 100;
            default: x.re_in = $urandom;
        endcase
        x.im_in = ($urandom_range(4) == 0) ? 32'h8000_0000 : $urandom;
        return x;
    endfunction

    initial begin
        fdmf_pkg::t_in_s x;
        logic [13:0] cuts [6] = '{14'd1, 14'd16383, 14'd480, 14'd0, 14'd40, 14'd2000};
        logic [3:0] lgs [5] = '{4'd1, 4'd9, 4'd8, 4'd0, 4'd15};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: corners and extremes, every mode incl. unused code 7
        for (int m = 0; m < 8; m++) begin
            write_reg(fdmf_pkg::REG_MODE, 14'(m));
            write_reg(fdmf_pkg::REG_CUTOFF, (m == 7) ? 14'd0 : 14'd480);
            write_reg(fdmf_pkg::REG_LOG2, 14'd8);
            x = '{col: 9'd128, row: 9'd128, re_in: 32'h7FFF_FFFF, im_in: 32'h8000_0000};
            send(x);
            x = '{col: 9'd158, row: 9'd128, re_in: -32'sd3, im_in: 32'sd3};
            send(x);
            x = '{col: 9'd511, row: 9'd0, re_in: 32'hFFFF_FFFF, im_in: 32'h0000_0001};
            send(x);
            drain();
        end
        // index past the last register is ignored
        write_reg(2'd3, 14'h3FFF);
        // random phases across settings
        for (int ph = 0; ph < 24; ph++) begin
            write_reg(fdmf_pkg::REG_MODE, (ph < 21) ? 14'(ph % 7) : 14'($urandom_range(7)));
            write_reg(fdmf_pkg::REG_CUTOFF, (ph % 4 == 3) ? 14'($urandom) : cuts[ph % 6]);
            write_reg(fdmf_pkg::REG_LOG2,
                      (ph % 5 == 4) ? 14'($urandom_range(9, 1)) : 14'(lgs[ph % 5]));
            quiet = (ph == 10) ? 1 : 0;
            for (int i = 0; i < 75; i++) send(rnd_coeff(cur_lg));
            drain();
        end
        if (errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
